// ===== sv/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the push-button debounce and long-press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Width of the hold counter, and of the limit register.
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned LIMIT_WIDTH = 16;
  // Both values are compared at the wider of the two widths.
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

  // Configuration register indexes.
  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(100);

  typedef enum logic [2:0] {
    MODE_RELEASED = 3'b001,
    MODE_PRESSED  = 3'b010,
    MODE_WAITREL  = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_LONG_PRESS   = 3'd3,
    EV_LONG_RELEASE = 3'd4
  } event_e;

  typedef struct packed {
    logic                   older;
    logic                   oldest;
    logic                   debounced;
    mode_e                  mode;
    logic [COUNT_WIDTH-1:0] hold;
  } state_t;

endpackage

// ===== sv/bdlp_step.sv =====
// ----------------------------------------------------------------------------
// bdlp_step
// Next-state and event logic for one sample: filter, then button state machine.
// ----------------------------------------------------------------------------
module bdlp_step (
  input  bdlp_pkg::state_t                   state_i,
  input  logic                               pin_level_i,
  input  logic                               enabled_i,
  input  logic [bdlp_pkg::LIMIT_WIDTH-1:0]   limit_i,
  output bdlp_pkg::state_t                   state_o,
  output bdlp_pkg::event_e                   event_o,
  output logic                               filtered_level_o
);

  logic any_high;
  logic all_high;
  logic level;
  logic pressed;
  logic count_full;
  logic over_limit;

  assign any_high = pin_level_i | state_i.older | state_i.oldest;
  assign all_high = pin_level_i & state_i.older & state_i.oldest;
  assign level    = (state_i.debounced & any_high) | all_high;
  assign pressed  = ~level;

  assign count_full = &state_i.hold;
  assign over_limit = bdlp_pkg::CMP_WIDTH'(state_i.hold) > bdlp_pkg::CMP_WIDTH'(limit_i);

  always_comb begin
    state_o          = state_i;
    event_o          = bdlp_pkg::EV_NONE;
    filtered_level_o = state_i.debounced;
    if (enabled_i) begin
      state_o.older     = pin_level_i;
      state_o.oldest    = state_i.older;
      state_o.debounced = level;
      filtered_level_o  = level;
      unique case (state_i.mode)
        bdlp_pkg::MODE_RELEASED: begin
          if (pressed) begin
            state_o.mode = bdlp_pkg::MODE_PRESSED;
            event_o      = bdlp_pkg::EV_PRESS;
          end
        end
        bdlp_pkg::MODE_PRESSED: begin
          if (pressed) begin
            if (!count_full) begin
              state_o.hold = state_i.hold + 1'b1;
            end
            // The limit is checked against the count before this increment.
            if (over_limit) begin
              state_o.hold = '0;
              state_o.mode = bdlp_pkg::MODE_WAITREL;
              event_o      = bdlp_pkg::EV_LONG_PRESS;
            end
          end else begin
            state_o.hold = '0;
            state_o.mode = bdlp_pkg::MODE_RELEASED;
            event_o      = bdlp_pkg::EV_RELEASE;
          end
        end
        bdlp_pkg::MODE_WAITREL: begin
          if (!pressed) begin
            state_o.mode = bdlp_pkg::MODE_RELEASED;
            event_o      = bdlp_pkg::EV_LONG_RELEASE;
          end
        end
        default: begin
          state_o.mode = bdlp_pkg::MODE_RELEASED;
        end
      endcase
    end
  end

endmodule

// ===== sv/button_debounce_long_press_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounces an active-low push-button sample stream and reports press, release,
// long-press and long-release events, one result per sample.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   -------  ---------  ----------------------  ------------------------------
//   in       input      in_valid_i/in_ready_o   pin_level_i
//   out      output     out_valid_o/out_ready_i event_code_o, filtered_level_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each sample is captured in an input register and then passes the filter and
// state machine into the result register, which presents it on the output
// channel. Both stages advance every cycle that nothing is stalled, giving a
// sustained rate of one sample per cycle; the button state feeds back from its
// register into the step logic. A stalled output holds both stages in turn
// while they are full. Reset returns the filter to released, the mode to
// released, the counter to zero, enabled to one and the limit to 100.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        pin_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_code_o,
  output logic        filtered_level_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic                             enabled_q;
  logic [bdlp_pkg::LIMIT_WIDTH-1:0] limit_q;

  // Input stage.
  logic in_valid_q;
  logic pin_q;

  // Button state and result register.
  bdlp_pkg::state_t state_q, state_d;
  bdlp_pkg::event_e event_d;
  logic             filt_d;
  logic             out_valid_q;
  logic [2:0]       event_q;
  logic             filt_q;

  logic out_free;
  logic advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      limit_q   <= bdlp_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bdlp_pkg::CFG_ENABLED: enabled_q <= cfg_data_i[0];
        bdlp_pkg::CFG_LIMIT:   limit_q   <= cfg_data_i[bdlp_pkg::LIMIT_WIDTH-1:0];
        default:               ;
      endcase
    end
  end

  // The result register frees when it is empty or being read this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pin_q <= pin_level_i;
    end
  end

  bdlp_step u_step (
    .state_i          (state_q),
    .pin_level_i      (pin_q),
    .enabled_i        (enabled_q),
    .limit_i          (limit_q),
    .state_o          (state_d),
    .event_o          (event_d),
    .filtered_level_o (filt_d)
  );

  // The button state moves only when a sample leaves the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.older     <= 1'b1;
      state_q.oldest    <= 1'b1;
      state_q.debounced <= 1'b1;
      state_q.mode      <= bdlp_pkg::MODE_RELEASED;
      state_q.hold      <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
      filt_q  <= filt_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_code_o     = event_q;
  assign filtered_level_o = filt_q;

endmodule
